@@ rtl/coo_sparse_matvec_assert.svh @@
// Assertion macros for the sparse matrix-vector block checker.
// Used by csmv_checker; expects clk and rst_n in scope.
`ifndef COO_SPARSE_MATVEC_ASSERT_SVH
`define COO_SPARSE_MATVEC_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSMV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CSMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/csmv_pkg.sv @@
// Shared constants, item types, state encoding and index helpers for the
// sparse matrix-vector block. No dependencies.
`default_nettype none

package csmv_pkg;

    localparam int VECTOR_DEPTH = 4096;
    localparam int MAX_ROWS     = 65536;

    localparam int ROW_W = 16;
    localparam int COL_W = 12;
    localparam int VAL_W = 32;
    localparam int ACC_W = 48;
    localparam int FRAC_W = 16;

    localparam int VEC_AW    = $clog2(VECTOR_DEPTH);
    localparam int COL_EXT_W = (VEC_AW > COL_W) ? VEC_AW : COL_W;
    localparam int ROW_CMP_W = (($clog2(MAX_ROWS) + 1) > (ROW_W + 1)) ?
                               ($clog2(MAX_ROWS) + 1) : (ROW_W + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int MUL_OP_W = VAL_W + 1;
    localparam int MUL_W    = 2 * MUL_OP_W;

    localparam logic signed [VAL_W-1:0] ALPHA_RESET = 32'sd65536;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_NONZERO = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        col_index;
        logic signed [VAL_W-1:0] value;
        logic                    final_entry;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic signed [VAL_W-1:0] row_sum;
        logic                    saturated;
        logic                    end_of_run;
    } result_t;

    // nonzero with its vector element, as queued between front and back
    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] elem;
        logic                    final_entry;
        logic                    row_ok;
    } nz_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROD,
        BK_ACC,
        BK_HI,
        BK_LO,
        BK_OUT
    } back_state_t;

    function automatic logic col_in_range(input logic [COL_W-1:0] col);
        logic [COL_EXT_W:0] ext;
        ext = (COL_EXT_W + 1)'(col);
        return ext < (COL_EXT_W + 1)'(VECTOR_DEPTH);
    endfunction

    function automatic logic [VEC_AW-1:0] col_addr(input logic [COL_W-1:0] col);
        logic [COL_EXT_W-1:0] ext;
        ext = COL_EXT_W'(col);
        return ext[VEC_AW-1:0];
    endfunction

    function automatic logic row_in_range(input logic [ROW_W-1:0] row);
        logic [ROW_CMP_W-1:0] ext;
        ext = ROW_CMP_W'(row);
        return ext < ROW_CMP_W'(MAX_ROWS);
    endfunction

endpackage

`default_nettype wire

@@ rtl/csmv_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/csmv_queue.sv @@
// Short register queue of nonzero entries between front and back.
// Depends on csmv_pkg.
`default_nettype none

module csmv_queue
    import csmv_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire nz_entry_t           push_entry,
    input  wire logic                pop,
    output      nz_entry_t           head,
    output      logic                empty,
    output      logic [QUEUE_CW-1:0] count
);

    nz_entry_t           mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    function automatic logic [QUEUE_AW-1:0] wrap_inc(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] n;
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

@@ rtl/csmv_front.sv @@
// Front end: takes input items, writes vector loads into the store and
// looks up the element for each nonzero before queueing it. Uses csmv_pkg,
// csmv_ram.
`default_nettype none

module csmv_front
    import csmv_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output      logic                item_ready,
    input  wire item_t               item_data,
    input  wire logic [QUEUE_CW-1:0] queue_count,
    output      logic                push,
    output      nz_entry_t           push_entry
);

    logic                    accept;
    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [VAL_W-1:0]        ram_rd_data;
    logic [VEC_AW-1:0]       addr;
    logic                    col_ok;

    logic                    pend_valid_reg, pend_valid_next;
    logic [ROW_W-1:0]        pend_row_reg;
    logic signed [VAL_W-1:0] pend_value_reg;
    logic                    pend_fin_reg;
    logic                    pend_row_ok_reg;
    logic                    pend_col_ok_reg;

    // credit check: queue plus the lookup in flight must leave a free slot
    assign item_ready = ((QUEUE_CW + 1)'(queue_count) + (QUEUE_CW + 1)'(pend_valid_reg))
                        < (QUEUE_CW + 1)'(QUEUE_DEPTH);
    assign accept = item_valid && item_ready;
    assign addr   = col_addr(item_data.col_index);
    assign col_ok = col_in_range(item_data.col_index);

    always_comb
    begin
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        pend_valid_next = 1'b0;
        if (accept)
        begin
            unique case (item_data.action)
                ACT_LOAD:
                begin
                    ram_wr_en = col_ok;
                end
                ACT_NONZERO:
                begin
                    ram_rd_en       = col_ok;
                    pend_valid_next = 1'b1;
                end
                default:
                begin
                    ram_wr_en = 1'b0;
                end
            endcase
        end
    end

    csmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr),
        .wr_data (item_data.value),
        .rd_en   (ram_rd_en),
        .rd_addr (addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_next)
        begin
            pend_row_reg    <= item_data.row_index;
            pend_value_reg  <= item_data.value;
            pend_fin_reg    <= item_data.final_entry;
            pend_row_ok_reg <= row_in_range(item_data.row_index);
            pend_col_ok_reg <= col_ok;
        end
    end

    // a column beyond the store multiplies by zero
    always_comb
    begin
        push                   = pend_valid_reg;
        push_entry.row_index   = pend_row_reg;
        push_entry.value       = pend_value_reg;
        push_entry.elem        = pend_col_ok_reg ? ram_rd_data : '0;
        push_entry.final_entry = pend_fin_reg;
        push_entry.row_ok      = pend_row_ok_reg;
    end

endmodule

`default_nettype wire

@@ rtl/csmv_back.sv @@
// Back end: row accumulation and scaled, saturated emission of row sums,
// all sharing one 33x33 signed multiplier. Uses csmv_pkg.
`default_nettype none

module csmv_back
    import csmv_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic signed [VAL_W-1:0] alpha,
    input  wire nz_entry_t               head,
    input  wire logic                    empty,
    output      logic                    pop,
    output      logic                    result_valid,
    input  wire logic                    result_ready,
    output      result_t                 result_data
);

    localparam logic signed [MUL_W-1:0] SAT_MAX = MUL_W'(64'sh7FFF_FFFF);
    localparam logic signed [MUL_W-1:0] SAT_MIN = -SAT_MAX - 1;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

    back_state_t             state_reg, state_next;
    nz_entry_t               work_reg, work_next;
    logic [ROW_W-1:0]        cur_row_reg, cur_row_next;
    logic signed [ACC_W-1:0] sum_reg, sum_next;
    logic                    open_reg, open_next;
    logic                    final_flush_reg, final_flush_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;
    logic signed [MUL_W-1:0] mul_reg, mul_next;
    logic signed [MUL_W-1:0] hi_prod_reg, hi_prod_next;

    logic                    mul_en;
    logic signed [MUL_OP_W-1:0] mul_a;
    logic signed [MUL_OP_W-1:0] mul_b;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W:0]   acc_wide;
    logic signed [MUL_W-1:0] scaled;

    assign mul_next = mul_a * mul_b;
    // product of two Q16.16 values, floored to Q16.16; always fits 48 bits
    assign prod     = $signed(mul_reg[ACC_W+FRAC_W-1:FRAC_W]);
    assign acc_wide = $signed({sum_reg[ACC_W-1], sum_reg}) + $signed({prod[ACC_W-1], prod});
    // alpha*hi + floor(alpha*lo / 2^16) == floor(alpha*sum / 2^16)
    assign scaled   = hi_prod_reg + (mul_reg >>> FRAC_W);

    always_comb
    begin
        state_next       = state_reg;
        work_next        = work_reg;
        cur_row_next     = cur_row_reg;
        sum_next         = sum_reg;
        open_next        = open_reg;
        final_flush_next = final_flush_reg;
        out_next         = out_reg;
        hi_prod_next     = hi_prod_reg;
        out_valid_next   = out_valid_reg;
        pop              = 1'b0;
        mul_en           = 1'b0;
        mul_a            = {alpha[VAL_W-1], alpha};
        mul_b            = '0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    work_next = head;
                    if (head.row_ok && open_reg && (head.row_index != cur_row_reg))
                    begin
                        final_flush_next = 1'b0;
                        state_next       = BK_HI;
                    end
                    else if (head.row_ok)
                    begin
                        state_next = BK_PROD;
                    end
                    else if (head.final_entry && open_reg)
                    begin
                        final_flush_next = 1'b1;
                        state_next       = BK_HI;
                    end
                end
            end
            BK_PROD:
            begin
                mul_en     = 1'b1;
                mul_a      = {work_reg.value[VAL_W-1], work_reg.value};
                mul_b      = {work_reg.elem[VAL_W-1], work_reg.elem};
                state_next = BK_ACC;
            end
            BK_ACC:
            begin
                if (acc_wide[ACC_W] != acc_wide[ACC_W-1])
                begin
                    sum_next = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
                end
                else
                begin
                    sum_next = acc_wide[ACC_W-1:0];
                end
                cur_row_next = work_reg.row_index;
                open_next    = 1'b1;
                if (work_reg.final_entry)
                begin
                    final_flush_next = 1'b1;
                    state_next       = BK_HI;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_HI:
            begin
                mul_en     = 1'b1;
                mul_b      = {sum_reg[ACC_W-1], sum_reg[ACC_W-1:FRAC_W]};
                state_next = BK_LO;
            end
            BK_LO:
            begin
                hi_prod_next = mul_reg;
                mul_en       = 1'b1;
                mul_b        = {{(MUL_OP_W - FRAC_W){1'b0}}, sum_reg[FRAC_W-1:0]};
                state_next   = BK_OUT;
            end
            BK_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.out_row    = cur_row_reg;
                    out_next.end_of_run = final_flush_reg || !work_reg.final_entry;
                    if (scaled > SAT_MAX)
                    begin
                        out_next.row_sum   = SAT_MAX[VAL_W-1:0];
                        out_next.saturated = 1'b1;
                    end
                    else if (scaled < SAT_MIN)
                    begin
                        out_next.row_sum   = SAT_MIN[VAL_W-1:0];
                        out_next.saturated = 1'b1;
                    end
                    else
                    begin
                        out_next.row_sum   = scaled[VAL_W-1:0];
                        out_next.saturated = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    if (final_flush_reg)
                    begin
                        open_next  = 1'b0;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_PROD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            cur_row_reg     <= '0;
            sum_reg         <= '0;
            open_reg        <= 1'b0;
            final_flush_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_row_reg     <= cur_row_next;
            sum_reg         <= sum_next;
            open_reg        <= open_next;
            final_flush_reg <= final_flush_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        out_reg     <= out_next;
        hi_prod_reg <= hi_prod_next;
        if (mul_en)
        begin
            mul_reg <= mul_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

`default_nettype wire

@@ rtl/coo_sparse_matvec.sv @@
// Top level of the coordinate-format sparse matrix-vector block: alpha
// register, front end, entry queue and back end. Uses csmv_pkg, csmv_front,
// csmv_queue, csmv_back.
//
//   channel   signals                          direction  payload
//   item      item_valid/item_ready/item_data   in         item_t
//   result    result_valid/result_ready/...     out        result_t
//   cfg       cfg_valid/cfg_ready/cfg_data      in         alpha, Q16.16
//
// Each nonzero with a row in range passes through pop, multiply and accumulate
// in the back end, and each row sum it emits adds two passes through the
// shared multiplier, then scale and saturate.
// The front end takes one item a cycle until the four-entry queue fills.
// Reset clears the row state and sets alpha to 1.0; the vector store is not
// cleared and holds nothing defined until loaded. A stalled result holds the
// back end while the front end keeps filling the queue.
`default_nettype none

module coo_sparse_matvec
    import csmv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output      logic             item_ready,
    input  wire item_t            item_data,
    output      logic             result_valid,
    input  wire logic             result_ready,
    output      result_t          result_data,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [VAL_W-1:0] cfg_data
);

    logic signed [VAL_W-1:0] alpha_reg, alpha_next;
    logic [QUEUE_CW-1:0]     queue_count;
    logic                    push;
    nz_entry_t               push_entry;
    logic                    pop;
    nz_entry_t               head;
    logic                    empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        alpha_next = alpha_reg;
        if (cfg_valid && cfg_ready)
        begin
            alpha_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else
        begin
            alpha_reg <= alpha_next;
        end
    end

    csmv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_data   (item_data),
        .queue_count (queue_count),
        .push        (push),
        .push_entry  (push_entry)
    );

    csmv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .count      (queue_count)
    );

    csmv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .alpha        (alpha_reg),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

@@ rtl/csmv_checker.sv @@
// Port-level checks on the result stream of coo_sparse_matvec, bound to
// the top level. Uses csmv_pkg and coo_sparse_matvec_assert.svh.
`default_nettype none
`include "coo_sparse_matvec_assert.svh"

module csmv_checker
    import csmv_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result_data
);

    logic             take;
    logic             pend_end_reg, pend_end_next;
    logic [ROW_W-1:0] prev_row_reg, prev_row_next;

    assign take = result_valid && result_ready;

    // after a result that is not the last of its item, the next closes it
    always_comb
    begin
        pend_end_next = pend_end_reg;
        prev_row_next = prev_row_reg;
        if (take)
        begin
            pend_end_next = !result_data.end_of_run;
            prev_row_next = result_data.out_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_end_reg <= 1'b0;
            prev_row_reg <= '0;
        end
        else
        begin
            pend_end_reg <= pend_end_next;
            prev_row_reg <= prev_row_next;
        end
    end

    `CSMV_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result_data), "result item changed while stalled")

    `CSMV_ASSERT_NOW(a_sat_limit, result_valid && result_data.saturated,
        result_data.row_sum == 32'h7FFF_FFFF || result_data.row_sum == 32'h8000_0000,
        "saturated result not at a limit")

    `CSMV_ASSERT_NOW(a_pair_end, result_valid && pend_end_reg,
        result_data.end_of_run, "second result of an item lacks end_of_run")

    `CSMV_ASSERT_NOW(a_pair_row, result_valid && pend_end_reg,
        result_data.out_row != prev_row_reg, "row flush and new row share an index")

endmodule

bind coo_sparse_matvec csmv_checker u_checker (.*);

`default_nettype wire

@@ tb/csmv_row_sum_check.sv @@
// Checker for coo_sparse_matvec: mirrors the vector store and row accumulator,
// predicts each emitted row sum and compares it with what the block hands out.
// Depends on csmv_pkg for the item types and sizes.
`timescale 1ns / 100ps

module csmv_row_sum_check
    import csmv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_ready,
    input  wire item_t            item_data,
    input  wire logic             result_valid,
    input  wire logic             result_ready,
    input  wire result_t          result_data,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [VAL_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    awaiting,
    output int                    results_checked,
    output int                    clipped_results
);

    localparam longint SUM_MAX = 64'sd140737488355327;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    logic signed [VAL_W-1:0] vec_copy [VECTOR_DEPTH];
    logic [ROW_W-1:0]        open_row;
    longint                  acc;
    bit                      row_active;
    logic signed [VAL_W-1:0] alpha_q;
    result_t                 row_sums_due [$];
    result_t                 due;

    // alpha * acc / 2^16, floored, split so nothing overflows 64 bits
    function automatic result_t scale_row(input logic [ROW_W-1:0] row, input bit last);
        longint  a;
        longint  hi;
        longint  lo;
        longint  r;
        result_t res;
        a  = longint'(alpha_q);
        hi = acc >>> FRAC_W;
        lo = acc & 64'hFFFF;
        r  = a * hi + ((a * lo) >>> FRAC_W);
        res.saturated = 1'b0;
        if (r > OUT_MAX) begin
            r = OUT_MAX;
            res.saturated = 1'b1;
        end
        if (r < OUT_MIN) begin
            r = OUT_MIN;
            res.saturated = 1'b1;
        end
        res.out_row    = row;
        res.row_sum    = r[VAL_W-1:0];
        res.end_of_run = last;
        return res;
    endfunction

    task automatic predict_item(input item_t it);
        longint prod;
        if (it.action == ACT_LOAD) begin
            if (int'(it.col_index) < VECTOR_DEPTH)
                vec_copy[it.col_index] = it.value;
        end
        else begin
            if (int'(it.row_index) < MAX_ROWS) begin
                prod = 0;
                if (int'(it.col_index) < VECTOR_DEPTH)
                    prod = (longint'(it.value) * longint'(vec_copy[it.col_index])) >>> FRAC_W;
                // any change of row closes the open one
                if (row_active && it.row_index != open_row) begin
                    row_sums_due.push_back(scale_row(open_row, !it.final_entry));
                    acc = 0;
                end
                open_row   = it.row_index;
                row_active = 1'b1;
                acc        = acc + prod;
                if (acc > SUM_MAX)
                    acc = SUM_MAX;
                if (acc < SUM_MIN)
                    acc = SUM_MIN;
            end
            if (it.final_entry && row_active) begin
                row_sums_due.push_back(scale_row(open_row, 1'b1));
                acc        = 0;
                row_active = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < VECTOR_DEPTH; i++)
                vec_copy[i] = '0;
            open_row        = '0;
            acc             = 0;
            row_active      = 1'b0;
            alpha_q         = ALPHA_RESET;
            row_sums_due.delete();
            mismatches      = 0;
            awaiting        = 0;
            results_checked = 0;
            clipped_results = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                alpha_q = cfg_data;
            // item first: a result at the same edge always belongs to an older item
            if (item_valid && item_ready)
                predict_item(item_data);
            if (result_valid && result_ready) begin
                if (row_sums_due.size() == 0) begin
                    $error("unexpected result: row %0d, sum %0d",
                           result_data.out_row, result_data.row_sum);
                    mismatches++;
                end
                else begin
                    due = row_sums_due.pop_front();
                    results_checked++;
                    if (due.saturated)
                        clipped_results++;
                    if (result_data.out_row !== due.out_row) begin
                        $error("out_row: expected %0d, got %0d",
                               due.out_row, result_data.out_row);
                        mismatches++;
                    end
                    if (result_data.row_sum !== due.row_sum) begin
                        $error("row_sum: expected %0d, got %0d",
                               due.row_sum, result_data.row_sum);
                        mismatches++;
                    end
                    if (result_data.saturated !== due.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               due.saturated, result_data.saturated);
                        mismatches++;
                    end
                    if (result_data.end_of_run !== due.end_of_run) begin
                        $error("end_of_run: expected %0b, got %0b",
                               due.end_of_run, result_data.end_of_run);
                        mismatches++;
                    end
                end
            end
            awaiting = row_sums_due.size();
        end
    end

endmodule

@@ tb/coo_sparse_matvec_tb.sv @@
// Top of the coo_sparse_matvec testbench: clock, reset, vector loads and
// nonzero streams, alpha writes and the verdict. Checking is done in
// csmv_row_sum_check; types come from csmv_pkg.
`timescale 1ns / 100ps

module coo_sparse_matvec_tb;
    import csmv_pkg::*;

    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 32;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SEGMENT_ITEMS = 100;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    item_t            item_data    = '0;
    logic             result_ready = 1'b0;
    logic             cfg_valid    = 1'b0;
    logic [VAL_W-1:0] cfg_data     = '0;
    wire logic        item_ready;
    wire logic        result_valid;
    wire result_t     result_data;
    wire logic        cfg_ready;

    int mismatches;
    int awaiting;
    int results_checked;
    int clipped_results;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_done     = 0;
    int loads_sent     = 0;
    int nonzeros_sent  = 0;
    int alpha_writes   = 0;
    int quiet_cycles   = 0;

    logic [COL_W-1:0] loaded_cols [$];

    coo_sparse_matvec i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    csmv_row_sum_check i_row_sum_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item_data       (item_data),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_data     (result_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked),
        .clipped_results (clipped_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stalls, or a long hold-off when one is asked for
    always @(negedge clk)
    begin
        if (holds_asked != holds_done)
        begin
            result_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            holds_done = holds_done + 1;
        end
        else
            result_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: nothing moved for %0d cycles, %0d row sums outstanding",
                     quiet_cycles, awaiting);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_item(input item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item_data  = it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
        if (it.action == ACT_LOAD)
            loads_sent++;
        else
            nonzeros_sent++;
    endtask

    task automatic load_elem(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
                             input logic fin);
        item_t it;
        it.action      = ACT_LOAD;
        it.row_index   = ROW_W'($urandom);     // ignored by loads
        it.col_index   = col;
        it.value       = val;
        it.final_entry = fin;
        push_item(it);
        loaded_cols.push_back(col);
    endtask

    task automatic send_nonzero(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                                input logic [VAL_W-1:0] val, input logic fin);
        item_t it;
        it.action      = ACT_NONZERO;
        it.row_index   = row;
        it.col_index   = col;
        it.value       = val;
        it.final_entry = fin;
        push_item(it);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    // only columns already loaded, never an undefined element
    function automatic logic [COL_W-1:0] pick_col();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    task automatic drain_results();
        item_valid = 1'b0;
        wait (awaiting == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_alpha(input logic [VAL_W-1:0] a);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = a;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        alpha_writes++;
    endtask

    task automatic directed_items();
        load_elem(12'd0, 32'h7FFF_FFFF, 1'b1);   // final on a load with no row open
        load_elem(12'd4095, 32'h8000_0000, 1'b0);
        load_elem(12'd1, 32'h0001_0000, 1'b0);
        load_elem(12'd2, 32'hFFFF_0000, 1'b0);
        load_elem(12'hAAA, 32'h0000_8000, 1'b0);
        load_elem(12'h555, 32'h0003_0000, 1'b0);
        send_nonzero(16'd0, 12'd1, 32'h0001_0000, 1'b0);
        send_nonzero(16'd0, 12'hAAA, 32'hFFFF_FFFF, 1'b0);   // product floors to -1 lsb
        load_elem(12'd3, 32'h0002_0000, 1'b1);   // load mid-matrix, final ignored
        send_nonzero(16'd0, 12'd3, 32'h0000_8000, 1'b0);
        // 2^46 four times: accumulator clips, then the output clips
        repeat (4) send_nonzero(16'hFFFF, 12'd4095, 32'h8000_0000, 1'b0);
        send_nonzero(16'hFFFF, 12'd0, 32'h7FFF_FFFF, 1'b0);
        // rows out of order, row 5 emitted twice
        send_nonzero(16'd5, 12'd1, 32'h0001_0000, 1'b0);
        send_nonzero(16'd3, 12'd2, 32'h7FFF_FFFF, 1'b0);
        send_nonzero(16'd5, 12'h555, 32'h8000_0000, 1'b0);
        send_nonzero(16'd5, 12'd1, 32'h0000_0001, 1'b1);
        send_nonzero(16'd7, 12'd2, 32'h0001_0000, 1'b0);
        send_nonzero(16'hAAAA, 12'd0, 32'h5555_5555, 1'b1);  // two results from one item
        send_nonzero(16'h5555, 12'd4095, 32'h8000_0000, 1'b1);
    endtask

    // one well-formed matrix with random content, plus occasional noise
    task automatic send_matrix();
        int               n_rows;
        int               n_nz;
        logic [ROW_W-1:0] row;
        logic             fin;
        repeat ($urandom_range(0, 4))
            load_elem(COL_W'($urandom), rand_value(), 1'($urandom_range(1)));
        n_rows = $urandom_range(1, 6);
        row    = ($urandom_range(1) != 0) ? ROW_W'($urandom) : ROW_W'($urandom_range(0, 15));
        for (int r = 0; r < n_rows; r++)
        begin
            n_nz = $urandom_range(1, 4);
            for (int k = 0; k < n_nz; k++)
            begin
                fin = (r == n_rows - 1) && (k == n_nz - 1) && ($urandom_range(9) != 0);
                if ($urandom_range(11) == 0)
                    load_elem(COL_W'($urandom), rand_value(), 1'($urandom_range(1)));
                if ($urandom_range(19) == 0)
                    send_nonzero(ROW_W'($urandom), pick_col(), rand_value(),
                                 1'($urandom_range(7) == 0));
                send_nonzero(row, pick_col(), rand_value(), fin);
            end
            if ($urandom_range(7) == 0)
                row = row + ROW_W'($urandom_range(4, 40000));
            else
                row = row + ROW_W'($urandom_range(1, 3));
        end
    endtask

    task automatic run_segment(input int n_items);
        int start;
        start = loads_sent + nonzeros_sent;
        while (loads_sent + nonzeros_sent - start < n_items)
            send_matrix();
    endtask

    // result side held off while a row change on every item fills the block
    task automatic stall_burst();
        logic [ROW_W-1:0] row;
        row = ROW_W'($urandom);
        holds_asked++;
        repeat (30)
        begin
            send_nonzero(row, pick_col(), rand_value(), 1'b0);
            row = row + 1'b1;
        end
        send_nonzero(row, pick_col(), rand_value(), 1'b1);
        drain_results();
    endtask

    initial
    begin
        logic [VAL_W-1:0] alpha_plan [6];
        alpha_plan[0] = 32'h7FFF_FFFF;
        alpha_plan[1] = 32'h0000_0000;
        alpha_plan[2] = 32'h8000_0000;
        alpha_plan[3] = $urandom;
        alpha_plan[4] = 32'h0001_0000;
        alpha_plan[5] = 32'hFFFF_0000;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_items();

        for (int s = 0; s < 6; s++)
        begin
            if (s < 2)
            begin
                send_gap_pct   = 35;
                recv_stall_pct = 83;
            end
            else if (s < 4)
            begin
                send_gap_pct   = 83;
                recv_stall_pct = 35;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            write_alpha(alpha_plan[s]);
            if (s == 4)
                stall_burst();
            run_segment(SEGMENT_ITEMS);
        end

        drain_results();

        $display("Sent %0d vector loads and %0d nonzeros; %0d row sums checked, %0d clipped",
                 loads_sent, nonzeros_sent, results_checked, clipped_results);
        $display("alpha set %0d times (max, min, zero, 1.0, -1.0, random) under varied stalls",
                 alpha_writes);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
